// ===== rtl/rwm_pkg.sv =====
// ----------------------------------------------------------------------------
// rwm_pkg
// Shared types and constants for the response wait matcher: frame store
// geometry, acknowledgement size, configuration indexes, request codes, controller states and the store command bundle.
// ----------------------------------------------------------------------------
package rwm_pkg;

  // Frame store geometry.
  localparam int FRAME_BYTES = 64;
  localparam int ADDR_W      = $clog2(FRAME_BYTES);

  // Acknowledgement geometry (two 64-bit character registers).
  localparam int ACK_CHARS   = 16;
  localparam int ACK_IDX_W   = $clog2(ACK_CHARS);
  localparam int LEN_W       = $clog2(ACK_CHARS + 1);
  localparam int ACK_LEN_W   = 5;
  localparam int CFG_W       = 64;
  localparam int CFG_IDX_W   = 2;
  localparam int TICK_W      = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_LEN    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_FIRST  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_SECOND = CFG_IDX_W'(2);

  // Request codes.
  typedef enum logic [2:0] {
    REQ_BYTE  = 3'd0,
    REQ_EOF   = 3'd1,
    REQ_START = 3'd2,
    REQ_TICK  = 3'd3,
    REQ_CLEAR = 3'd4
  } req_e;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD,
    ST_CHK
  } state_e;

  // Commands toward the frame store, as driven in each cycle.
  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              clr_en;
    logic [ADDR_W-1:0] clr_addr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } store_cmd_t;

endpackage

// ===== rtl/rwm_frame_store.sv =====
// ----------------------------------------------------------------------------
// rwm_frame_store
// Byte store for the received frame: one synchronous memory with a write port
// and a registered read port, plus a valid bit per entry. An entry whose valid
// bit is clear reads as zero, which covers both the reset state and the zero
// terminator placed after the last received byte.
// ----------------------------------------------------------------------------
module rwm_frame_store (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rwm_pkg::store_cmd_t cmd_i,
  output logic [7:0]          rd_data_o
);
  import rwm_pkg::*;

  logic [7:0]             mem [FRAME_BYTES];
  logic [FRAME_BYTES-1:0] valid_q;
  logic [7:0]             rd_mem_q;
  logic                   rd_vld_q;

  // Memory write port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[cmd_i.wr_addr] <= cmd_i.wr_data;
    end
  end

  // Memory read port, registered.
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_mem_q <= mem[cmd_i.rd_addr];
    end
  end

  // Valid bits: a write marks an entry, a clear returns it to zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (cmd_i.wr_en) begin
        valid_q[cmd_i.wr_addr] <= 1'b1;
      end
      if (cmd_i.clr_en) begin
        valid_q[cmd_i.clr_addr] <= 1'b0;
      end
      if (cmd_i.rd_en) begin
        rd_vld_q <= valid_q[cmd_i.rd_addr];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_mem_q : 8'h00;

endmodule

// ===== rtl/response_wait_matcher.sv =====
// ----------------------------------------------------------------------------
// response_wait_matcher
// Collects received serial bytes into a frame store and waits, tick by tick,
// for an expected acknowledgement text inside the received frame.
//
// Usage: requests enter on the input channel (in_valid_i / in_stall_o) with
// req_type_i selecting received byte, end of frame, start wait, tick or clear
// frame. A request that yields a result (start wait without need or with zero
// ticks, timeout, empty pattern outside a frame, or acknowledgement found)
// drives one item on the output channel (out_valid_o / out_stall_i) in the
// cycle after it completes. Byte, end of frame, clear and start requests
// complete when accepted. A tick that must look for the acknowledgement scans
// the frame store through its single read port, a read and a check state per
// stored byte; the scan stops at a match, the first zero byte or the last entry.
// The result sits in one register; while it is held there and stalled, every
// new request is stalled as well, whether or not it would produce a result.
// Reset empties the frame store at once via per-entry valid bits (no clearing
// pass), clears control flags but not the result status, clears the countdown
// and zeroes the ack registers. Configuration writes are taken in any cycle.
// ----------------------------------------------------------------------------
module response_wait_matcher (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         cfg_we_i,
  input  logic [rwm_pkg::CFG_IDX_W-1:0] cfg_addr_i,
  input  logic [rwm_pkg::CFG_W-1:0]    cfg_data_i,
  // request channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [2:0]                   req_type_i,
  input  logic [7:0]                   rx_byte_i,
  input  logic [rwm_pkg::TICK_W-1:0]   wait_ticks_i,
  input  logic                         need_ack_i,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         wait_status_o
);
  import rwm_pkg::*;

  // Configuration registers.
  logic [ACK_LEN_W-1:0] ack_len_q;
  logic [CFG_W-1:0]     ack_first_q;
  logic [CFG_W-1:0]     ack_second_q;

  // Control state.
  state_e               st_q, st_d;
  logic [ADDR_W-1:0]    wp_q, wp_d;
  logic                 recv_q, recv_d;
  logic                 wait_q, wait_d;
  logic [TICK_W-1:0]    cnt_q, cnt_d;
  logic                 out_valid_q, out_valid_d;
  logic                 status_q, status_d;

  // Scan state.
  logic [ADDR_W-1:0]    scan_addr_q, scan_addr_d;
  logic [LEN_W-1:0]     seen_q, seen_d;
  logic [LEN_W-1:0]     k_q, k_d;
  logic [7:0]           win_q [ACK_CHARS];
  logic [7:0]           win_d [ACK_CHARS];
  logic [7:0]           rpat_q [ACK_CHARS];
  logic [7:0]           rpat_d [ACK_CHARS];

  // Pattern derived from configuration.
  logic [7:0]           ack_b [ACK_CHARS];
  logic [LEN_W-1:0]     lim;
  logic [LEN_W-1:0]     k_cfg;
  logic [7:0]           rpat_cfg [ACK_CHARS];

  store_cmd_t           cmd;
  logic [7:0]           rd_data;
  logic                 accept;
  logic                 emit;
  logic                 emit_status;
  logic                 start_scan;
  logic                 scan_hit;
  logic                 scan_stop;
  logic [TICK_W-1:0]    cnt_dec;
  req_e                 req;

  assign req    = req_e'(req_type_i);
  assign accept = in_valid_i && !in_stall_o;
  assign cnt_dec = cnt_q - TICK_W'(1);

  // Requests wait while a scan runs or while a held result is blocked.
  assign in_stall_o = (st_q != ST_IDLE) || (out_valid_q && out_stall_i);

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ack_len_q    <= '0;
      ack_first_q  <= '0;
      ack_second_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_ACK_LEN:    ack_len_q    <= cfg_data_i[ACK_LEN_W-1:0];
        CFG_ACK_FIRST:  ack_first_q  <= cfg_data_i;
        CFG_ACK_SECOND: ack_second_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective pattern length: clamped, and cut at the first zero character.
  always_comb begin
    for (int i = 0; i < ACK_CHARS; i++) begin
      ack_b[i] = (i < 8) ? ack_first_q[8*(i%8) +: 8] : ack_second_q[8*(i%8) +: 8];
    end
    lim = (ack_len_q > ACK_LEN_W'(ACK_CHARS)) ? LEN_W'(ACK_CHARS) : LEN_W'(ack_len_q);
    k_cfg = lim;
    for (int i = ACK_CHARS - 1; i >= 0; i--) begin
      if ((LEN_W'(i) < lim) && (ack_b[i] == 8'h00)) begin
        k_cfg = LEN_W'(i);
      end
    end
  end

  // Reversed pattern so that the newest window byte lines up with the last
  // pattern character.
  always_comb begin
    logic [LEN_W-1:0] idx;
    for (int j = 0; j < ACK_CHARS; j++) begin
      idx = k_cfg - LEN_W'(1) - LEN_W'(j);
      rpat_cfg[j] = (LEN_W'(j) < k_cfg) ? ack_b[idx[ACK_IDX_W-1:0]] : 8'h00;
    end
  end

  // Shift the read byte into the window and compare against the pattern.
  always_comb begin
    logic all_eq;
    win_d[0] = rd_data;
    for (int j = 1; j < ACK_CHARS; j++) begin
      win_d[j] = win_q[j-1];
    end
    seen_d = (seen_q < LEN_W'(ACK_CHARS)) ? seen_q + LEN_W'(1) : seen_q;
    all_eq = 1'b1;
    for (int j = 0; j < ACK_CHARS; j++) begin
      if ((LEN_W'(j) < k_q) && (win_d[j] != rpat_q[j])) begin
        all_eq = 1'b0;
      end
    end
    scan_hit  = (rd_data != 8'h00) && (seen_d >= k_q) && all_eq;
    scan_stop = (rd_data == 8'h00) || (scan_addr_q == ADDR_W'(FRAME_BYTES - 1));
  end

  // Tick that needs the frame scanned.
  assign start_scan = accept && (req == REQ_TICK) && wait_q && (cnt_dec != '0)
                      && !recv_q && (k_cfg != '0);

  // Next state.
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE: if (start_scan) st_d = ST_RD;
      ST_RD:   st_d = ST_CHK;
      ST_CHK:  st_d = (scan_hit || scan_stop) ? ST_IDLE : ST_RD;
      default: st_d = ST_IDLE;
    endcase
  end

  // Request handling, store commands and scan control.
  always_comb begin
    cmd         = '0;
    wp_d        = wp_q;
    recv_d      = recv_q;
    wait_d      = wait_q;
    cnt_d       = cnt_q;
    emit        = 1'b0;
    emit_status = 1'b0;
    scan_addr_d = scan_addr_q;
    k_d         = k_q;
    rpat_d      = rpat_q;

    unique case (st_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (req)
            REQ_BYTE: begin
              if (wp_q == ADDR_W'(FRAME_BYTES - 1)) begin
                cmd.clr_en   = 1'b1;
                cmd.clr_addr = wp_q;
              end else begin
                cmd.wr_en    = 1'b1;
                cmd.wr_addr  = wp_q;
                cmd.wr_data  = rx_byte_i;
                cmd.clr_en   = 1'b1;
                cmd.clr_addr = wp_q + ADDR_W'(1);
                wp_d         = wp_q + ADDR_W'(1);
              end
              recv_d = 1'b1;
            end
            REQ_EOF: begin
              recv_d = 1'b0;
              wp_d   = '0;
            end
            REQ_CLEAR: begin
              cmd.clr_en   = 1'b1;
              cmd.clr_addr = '0;
              recv_d       = 1'b0;
              wp_d         = '0;
            end
            REQ_START: begin
              if (!need_ack_i || (wait_ticks_i == '0)) begin
                wait_d = 1'b0;
                emit   = 1'b1;
              end else begin
                cnt_d  = wait_ticks_i;
                wait_d = 1'b1;
              end
            end
            REQ_TICK: begin
              if (wait_q) begin
                cnt_d = cnt_dec;
                if (cnt_dec == '0) begin
                  wait_d      = 1'b0;
                  emit        = 1'b1;
                  emit_status = 1'b1;
                end else if (!recv_q && (k_cfg == '0)) begin
                  wait_d = 1'b0;
                  emit   = 1'b1;
                end else if (start_scan) begin
                  scan_addr_d = '0;
                  k_d         = k_cfg;
                  rpat_d      = rpat_cfg;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_RD: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = scan_addr_q;
      end
      ST_CHK: begin
        if (scan_hit) begin
          wait_d = 1'b0;
          emit   = 1'b1;
        end else if (!scan_stop) begin
          scan_addr_d = scan_addr_q + ADDR_W'(1);
        end
      end
      default: ;
    endcase

    // Result register: load on a new result, drop once taken.
    out_valid_d = out_valid_q && out_stall_i;
    status_d    = status_q;
    if (emit) begin
      out_valid_d = 1'b1;
      status_d    = emit_status;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      wp_q        <= '0;
      recv_q      <= 1'b0;
      wait_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      scan_addr_q <= '0;
      seen_q      <= '0;
    end else begin
      st_q        <= st_d;
      wp_q        <= wp_d;
      recv_q      <= recv_d;
      wait_q      <= wait_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      scan_addr_q <= scan_addr_d;
      if (start_scan) begin
        seen_q <= '0;
      end else if (st_q == ST_CHK) begin
        seen_q <= seen_d;
      end
    end
  end

  // Payload registers: window, pattern and result status.
  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    k_q      <= k_d;
    rpat_q   <= rpat_d;
    if (st_q == ST_CHK) begin
      win_q <= win_d;
    end
  end

  rwm_frame_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .rd_data_o (rd_data)
  );

  assign out_valid_o   = out_valid_q;
  assign wait_status_o = status_q;

endmodule
